// File: rtl/core/light_meter_measurement_sequencer_assert.svh
// Assertion macros shared by the light meter sequencer RTL.
// Included by name; needs nothing else. Synthesis sees empty bodies.
`ifndef LIGHT_METER_MEASUREMENT_SEQUENCER_ASSERT_SVH
`define LIGHT_METER_MEASUREMENT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define LMMS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define LMMS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define LMMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LMMS_ASSERT_ALWAYS(label, clk, rst, expr)
`define LMMS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LMMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/lmms_pkg.sv
// Types and constants of the light meter measurement sequencer.
// No dependencies; lmms_csr, lmms_seq and the top level import this package.
`default_nettype none

package lmms_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_ABORT = 2'd2,
      OP_TAKE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAGE_IDLE  = 3'd0,
      STAGE_PRE   = 3'd1,
      STAGE_GWAIT = 3'd2,
      STAGE_GREAD = 3'd3,
      STAGE_LWAIT = 3'd4,
      STAGE_CAPT  = 3'd5,
      STAGE_POST  = 3'd6,
      STAGE_DONE  = 3'd7
   } stage_type;

   typedef enum logic [1:0] {
      GAIN_LOW  = 2'd0,
      GAIN_MED  = 2'd1,
      GAIN_HIGH = 2'd2,
      GAIN_MAX  = 2'd3
   } gain_type;

   typedef enum logic [1:0] {
      BEEP_NONE    = 2'd0,
      BEEP_SUCCESS = 2'd1,
      BEEP_WARNING = 2'd2
   } beep_type;

   typedef enum logic [1:0] {
      CSR_PRE_WAIT   = 2'd0,
      CSR_POST_WAIT  = 2'd1,
      CSR_SATURATION = 2'd2,
      CSR_SENSOR     = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_WIDTH = 16;

   localparam logic [15:0] PRE_WAIT_RESET   = 16'd500;
   localparam logic [15:0] POST_WAIT_RESET  = 16'd500;
   localparam logic [15:0] SATURATION_RESET = 16'd36863;

   localparam logic [31:0] GAIN_SETTLE_MS = 32'd120;
   localparam logic [31:0] LONG_WAIT_MS   = 32'd650;
   localparam logic [15:0] LOW_COUNT      = 16'd300;
   localparam logic [15:0] VERY_LOW_COUNT = 16'd50;
   localparam logic [2:0]  MAX_TRIES      = 3'd4;
   localparam logic [2:0]  TRY_LIMIT      = 3'd7;

   // Progress during the long wait is 20 + floor(e*6/65) for e up to 650.
   // floor(x/65) equals (x*4033)>>18 for every x below 4096.
   localparam logic [11:0] RECIP_65       = 12'd4033;
   localparam int unsigned RECIP_SHIFT    = 18;
   localparam logic [6:0]  PROGRESS_PRE   = 7'd5;
   localparam logic [6:0]  PROGRESS_LBASE = 7'd20;
   localparam logic [6:0]  PROGRESS_CAPT  = 7'd90;
   localparam logic [6:0]  PROGRESS_DONE  = 7'd100;

   typedef struct packed {
      logic [15:0] pre_delay_ms;
      logic [15:0] post_delay_ms;
      logic [15:0] saturation_count;
      logic        sensor_present;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic        with_enlarger;
      logic        exposure_running;
      logic [15:0] channel_full;
      logic [15:0] channel_ir;
   } req_type;

   typedef struct packed {
      logic        accepted;
      stage_type   stage;
      logic [6:0]  progress;
      gain_type    sensor_gain;
      logic        gain_write;
      logic        long_integration;
      logic        enlarger_on;
      logic        safelight_on;
      logic        exposure_lock;
      beep_type    beep;
      logic [15:0] result_full;
      logic [15:0] result_ir;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/lmms_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Standalone; widths follow the fields of one request and one response.
`default_nettype none

interface lmms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic        with_enlarger;
   logic        exposure_running;
   logic [15:0] channel_full;
   logic [15:0] channel_ir;

   modport source (output valid, op, now_ms, with_enlarger, exposure_running,
                   channel_full, channel_ir, input ready);
   modport sink (input valid, op, now_ms, with_enlarger, exposure_running,
                 channel_full, channel_ir, output ready);
endinterface

interface lmms_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [2:0]  stage;
   logic [6:0]  progress;
   logic [1:0]  sensor_gain;
   logic        gain_write;
   logic        long_integration;
   logic        enlarger_on;
   logic        safelight_on;
   logic        exposure_lock;
   logic [1:0]  beep;
   logic [15:0] result_full;
   logic [15:0] result_ir;

   modport source (output valid, accepted, stage, progress, sensor_gain,
                   gain_write, long_integration, enlarger_on, safelight_on,
                   exposure_lock, beep, result_full, result_ir, input ready);
   modport sink (input valid, accepted, stage, progress, sensor_gain,
                 gain_write, long_integration, enlarger_on, safelight_on,
                 exposure_lock, beep, result_full, result_ir, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lmms_csr.sv
// Configuration registers of the light meter sequencer.
// Depends on lmms_pkg for the register indexes and the bundle type.
`default_nettype none

module lmms_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [lmms_pkg::CSR_WIDTH-1:0]  csr_wdata,
   output lmms_pkg::cfg_type               cfg
);
   import lmms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PRE_WAIT:   cfg_in.pre_delay_ms     = csr_wdata;
            CSR_POST_WAIT:  cfg_in.post_delay_ms    = csr_wdata;
            CSR_SATURATION: cfg_in.saturation_count = csr_wdata;
            CSR_SENSOR:     cfg_in.sensor_present   = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_delay_ms     <= PRE_WAIT_RESET;
         cfg_ff.post_delay_ms    <= POST_WAIT_RESET;
         cfg_ff.saturation_count <= SATURATION_RESET;
         cfg_ff.sensor_present   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/lmms_seq.sv
// Measurement state and its update for one request.
// Depends on lmms_pkg; the assertion macros come from the shared header.
`default_nettype none
`include "light_meter_measurement_sequencer_assert.svh"

module lmms_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  lmms_pkg::req_type  req,
   input  lmms_pkg::cfg_type  cfg,
   output lmms_pkg::rsp_type  rsp_in
);
   import lmms_pkg::*;

   stage_type   stage_ff, stage_in;
   logic [31:0] phase_ff, phase_in;
   logic [6:0]  progress_ff, progress_in;
   gain_type    gain_ff, gain_in;
   logic [2:0]  attempt_ff, attempt_in;
   logic        long_ff, long_in;
   logic [15:0] cap_full_ff, cap_full_in;
   logic [15:0] cap_ir_ff, cap_ir_in;
   logic        enl_ff, enl_in;
   logic        safe_ff, safe_in;
   logic        lock_ff, lock_in;

   logic        running;
   logic [31:0] elapsed;
   logic [9:0]  long_el;
   logic [11:0] long_x6;
   logic [23:0] long_prod;
   logic [6:0]  long_progress;
   gain_type    gain_try;
   logic        gain_changed;
   logic        accepted;
   logic        gain_write;
   beep_type    beep;
   logic        capture_tick;

   assign running = stage_ff inside {[STAGE_PRE:STAGE_POST]};
   assign elapsed = req.now_ms - phase_ff;

   // Long-wait progress: clamp to 650 ms, then scale by 60/650.
   // Six times the clamped time is formed as four times plus two times.
   assign long_el       = (elapsed < LONG_WAIT_MS) ? elapsed[9:0] : LONG_WAIT_MS[9:0];
   assign long_x6       = {long_el, 2'b00} + {1'b0, long_el, 1'b0};
   assign long_prod     = long_x6 * RECIP_65;
   assign long_progress = PROGRESS_LBASE + {1'b0, long_prod[23:RECIP_SHIFT]};

   // Gain ranging decision for a read; the count of tries caps it.
   always_comb begin
      gain_try     = gain_ff;
      gain_changed = 1'b1;
      if ((req.channel_full > cfg.saturation_count) && (gain_ff != GAIN_LOW)) begin
         gain_try = GAIN_LOW;
      end else if ((req.channel_full < LOW_COUNT) && (gain_ff == GAIN_LOW)) begin
         gain_try = GAIN_MED;
      end else if ((req.channel_full < LOW_COUNT) && (gain_ff == GAIN_MED)) begin
         gain_try = GAIN_HIGH;
      end else if ((req.channel_full < VERY_LOW_COUNT) && (gain_ff == GAIN_HIGH)) begin
         gain_try = GAIN_MAX;
      end else begin
         gain_changed = 1'b0;
      end
   end

   always_comb begin
      stage_in    = stage_ff;
      phase_in    = phase_ff;
      progress_in = progress_ff;
      gain_in     = gain_ff;
      attempt_in  = attempt_ff;
      long_in     = long_ff;
      cap_full_in = cap_full_ff;
      cap_ir_in   = cap_ir_ff;
      enl_in      = enl_ff;
      safe_in     = safe_ff;
      lock_in     = lock_ff;
      accepted    = 1'b0;
      gain_write  = 1'b0;
      beep        = BEEP_NONE;

      case (req.op)
         OP_TICK: begin
            if (!req.exposure_running && running) begin
               case (stage_ff)
                  STAGE_PRE: begin
                     progress_in = PROGRESS_PRE;
                     if (elapsed >= {16'd0, cfg.pre_delay_ms}) begin
                        gain_in    = GAIN_MED;
                        long_in    = 1'b0;
                        gain_write = 1'b1;
                        phase_in   = req.now_ms;
                        stage_in   = STAGE_GWAIT;
                     end
                  end
                  STAGE_GWAIT: begin
                     if (elapsed >= GAIN_SETTLE_MS) begin
                        stage_in = STAGE_GREAD;
                     end
                  end
                  STAGE_GREAD: begin
                     if (attempt_ff < TRY_LIMIT) begin
                        attempt_in = attempt_ff + 3'd1;
                     end
                     gain_write = 1'b1;
                     phase_in   = req.now_ms;
                     if (gain_changed && (attempt_in <= MAX_TRIES)) begin
                        gain_in  = gain_try;
                        long_in  = 1'b0;
                        stage_in = STAGE_GWAIT;
                     end else begin
                        long_in  = 1'b1;
                        stage_in = STAGE_LWAIT;
                     end
                  end
                  STAGE_LWAIT: begin
                     progress_in = long_progress;
                     if (elapsed >= LONG_WAIT_MS) begin
                        stage_in = STAGE_CAPT;
                     end
                  end
                  STAGE_CAPT: begin
                     progress_in = PROGRESS_CAPT;
                     cap_full_in = req.channel_full;
                     cap_ir_in   = req.channel_ir;
                     gain_in     = GAIN_MED;
                     long_in     = 1'b0;
                     gain_write  = 1'b1;
                     enl_in      = 1'b0;
                     safe_in     = 1'b0;
                     phase_in    = req.now_ms;
                     stage_in    = STAGE_POST;
                  end
                  STAGE_POST: begin
                     if (elapsed >= {16'd0, cfg.post_delay_ms}) begin
                        enl_in      = 1'b0;
                        safe_in     = 1'b1;
                        lock_in     = 1'b0;
                        progress_in = PROGRESS_DONE;
                        stage_in    = STAGE_DONE;
                        beep        = BEEP_SUCCESS;
                     end
                  end
                  default: begin
                     stage_in = stage_ff;
                  end
               endcase
            end
         end
         OP_START: begin
            if (!running && cfg.sensor_present) begin
               accepted    = 1'b1;
               cap_full_in = 16'd0;
               cap_ir_in   = 16'd0;
               progress_in = 7'd0;
               attempt_in  = 3'd0;
               enl_in      = req.with_enlarger;
               safe_in     = 1'b0;
               lock_in     = 1'b1;
               phase_in    = req.now_ms;
               stage_in    = STAGE_PRE;
            end
         end
         OP_ABORT: begin
            if (running) begin
               accepted    = 1'b1;
               enl_in      = 1'b0;
               safe_in     = 1'b1;
               lock_in     = 1'b0;
               progress_in = 7'd0;
               stage_in    = STAGE_IDLE;
               beep        = BEEP_WARNING;
            end
         end
         OP_TAKE: begin
            accepted = 1'b1;
            stage_in = STAGE_IDLE;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= STAGE_IDLE;
         phase_ff    <= 32'd0;
         progress_ff <= 7'd0;
         gain_ff     <= GAIN_MED;
         attempt_ff  <= 3'd0;
         long_ff     <= 1'b0;
         cap_full_ff <= 16'd0;
         cap_ir_ff   <= 16'd0;
         enl_ff      <= 1'b0;
         safe_ff     <= 1'b1;
         lock_ff     <= 1'b0;
      end else if (step) begin
         stage_ff    <= stage_in;
         phase_ff    <= phase_in;
         progress_ff <= progress_in;
         gain_ff     <= gain_in;
         attempt_ff  <= attempt_in;
         long_ff     <= long_in;
         cap_full_ff <= cap_full_in;
         cap_ir_ff   <= cap_ir_in;
         enl_ff      <= enl_in;
         safe_ff     <= safe_in;
         lock_ff     <= lock_in;
      end
   end

   // The response shows the state as it stands after this request.
   always_comb begin
      rsp_in.accepted         = accepted;
      rsp_in.stage            = stage_in;
      rsp_in.progress         = progress_in;
      rsp_in.sensor_gain      = gain_in;
      rsp_in.gain_write       = gain_write;
      rsp_in.long_integration = long_in;
      rsp_in.enlarger_on      = enl_in;
      rsp_in.safelight_on     = safe_in;
      rsp_in.exposure_lock    = lock_in;
      rsp_in.beep             = beep;
      rsp_in.result_full      = cap_full_in;
      rsp_in.result_ir        = cap_ir_in;
   end

   assign capture_tick = step && (stage_ff == STAGE_CAPT) && (req.op == OP_TICK)
                         && !req.exposure_running;

   // A running measurement always holds the exposure lock with the safelight off.
   `LMMS_ASSERT_IMPLIES(a_running_locked, clock, reset, running, lock_ff && !safe_ff)
   // Gain ranging never runs past its fifth try.
   `LMMS_ASSERT_ALWAYS(a_attempt_bound, clock, reset, attempt_ff <= 3'd5)
   // Leaving the capture stage on a step always latches the counts.
   `LMMS_ASSERT_NEXT(a_capture_latch, clock, reset, capture_tick, cap_full_ff == $past(req.channel_full))
   // The capture stage always hands over to the post-wait.
   `LMMS_ASSERT_NEXT(a_capture_stage, clock, reset, capture_tick, stage_ff == STAGE_POST)

endmodule

`default_nettype wire

// File: rtl/core/light_meter_measurement_sequencer.sv
// Top level of the light meter measurement sequencer.
// A request passes through the request register and then the response
// register before its response is offered.
// Throughput: one request per cycle while the sink keeps taking responses.
// Reset is synchronous and active high; it empties both registers,
// restores the configuration defaults and sets the measurement idle.
`default_nettype none
`include "light_meter_measurement_sequencer_assert.svh"

module light_meter_measurement_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   lmms_req_if.sink                        req_ch,
   lmms_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [lmms_pkg::CSR_WIDTH-1:0]  csr_wdata
);
   import lmms_pkg::*;

   // Request register: holds one transferred request until the state
   // update consumes it.
   req_type in_ff;
   req_type in_in;
   logic    in_valid_ff;
   logic    in_valid_in;

   // Response register: holds one finished response until the sink takes it.
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   cfg_type cfg;
   logic    advance;
   logic    step;
   logic    req_xfer;
   logic    rsp_success;
   logic    rsp_done;

   // The update runs whenever the response register can take a new value,
   // so a request keeps flowing while a finished response is being taken.
   // The payload is registered on both sides; the request ready follows
   // the response ready combinationally.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_in.op               = op_type'(req_ch.op);
      in_in.now_ms           = req_ch.now_ms;
      in_in.with_enlarger    = req_ch.with_enlarger;
      in_in.exposure_running = req_ch.exposure_running;
      in_in.channel_full     = req_ch.channel_full;
      in_in.channel_ir       = req_ch.channel_ir;
   end

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= in_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   lmms_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   lmms_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_ff),
      .cfg    (cfg),
      .rsp_in (rsp_in)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.accepted         = rsp_ff.accepted;
   assign rsp_ch.stage            = rsp_ff.stage;
   assign rsp_ch.progress         = rsp_ff.progress;
   assign rsp_ch.sensor_gain      = rsp_ff.sensor_gain;
   assign rsp_ch.gain_write       = rsp_ff.gain_write;
   assign rsp_ch.long_integration = rsp_ff.long_integration;
   assign rsp_ch.enlarger_on      = rsp_ff.enlarger_on;
   assign rsp_ch.safelight_on     = rsp_ff.safelight_on;
   assign rsp_ch.exposure_lock    = rsp_ff.exposure_lock;
   assign rsp_ch.beep             = rsp_ff.beep;
   assign rsp_ch.result_full      = rsp_ff.result_full;
   assign rsp_ch.result_ir        = rsp_ff.result_ir;

   assign rsp_success = rsp_valid_ff && (rsp_ff.beep == BEEP_SUCCESS);
   assign rsp_done    = (rsp_ff.stage == STAGE_DONE) && (rsp_ff.progress == PROGRESS_DONE);

   // A request that cannot advance stays in the request register.
   `LMMS_ASSERT_NEXT(a_hold_request, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // Progress never exceeds one hundred percent.
   `LMMS_ASSERT_IMPLIES(a_progress_range, clock, reset, rsp_valid_ff, rsp_ff.progress <= PROGRESS_DONE)
   // The success tone comes only with a finished measurement.
   `LMMS_ASSERT_IMPLIES(a_success_done, clock, reset, rsp_success, rsp_done)

endmodule

`default_nettype wire
